// File: src/pts_pkg.sv
// Shared types, codes and constants of the partition table scanner.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package pts_pkg;

    localparam int SECTOR_BYTES  = 512;
    localparam int MBR_SLOTS_DEF = 4;
    localparam int MBR_BASE      = 446;
    localparam int HDR_LBA_OFF   = 72;
    localparam int HDR_CNT_OFF   = 80;
    localparam int HDR_SIZE_OFF  = 84;
    localparam int MIN_ENTRY     = 48;

    localparam logic [7:0] SIG_LO   = 8'h55;
    localparam logic [7:0] SIG_HI   = 8'hAA;
    localparam logic [7:0] GPT_TYPE = 8'hEE;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_FAIL  = 2'd2;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MBR  = 2'd1;
    localparam logic [1:0] PH_HDR  = 2'd2;
    localparam logic [1:0] PH_ENT  = 2'd3;

    localparam logic REG_SCAN_MODE   = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    typedef struct packed {
        logic accept;
        logic check;
        logic walk;
        logic drain;
    } cmd_t;

    typedef struct packed {
        logic acc_pend;
        logic need_check;
        logic walk_start;
        logic check_pend;
        logic walk_done;
        logic load_last;
    } status_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  ptype;
        logic [31:0] pstart;
        logic [31:0] plen;
        logic        status;
        logic [15:0] count;
        logic        last;
    } res_t;

    function automatic logic [7:0] efi_magic(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0: c = 8'h45;
            3'd1: c = 8'h46;
            3'd2: c = 8'h49;
            3'd3: c = 8'h20;
            3'd4: c = 8'h50;
            3'd5: c = 8'h41;
            3'd6: c = 8'h52;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: src/pts_ctrl.sv
// Sequencing state machine of the partition table scanner.
// Depends on pts_pkg for the command and status structs.
`default_nettype none
module pts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  pts_pkg::status_t      st,
    output pts_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_WALK  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    priority if (st.need_check) state_next = S_CHECK;
                    else if (st.walk_start)     state_next = S_WALK;
                    else if (st.acc_pend)       state_next = S_DRAIN;
                    else                        state_next = S_IDLE;
                end
            end
            S_CHECK: state_next = st.check_pend ? S_DRAIN : S_IDLE;
            S_WALK:
            begin
                if (st.walk_done) state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (st.load_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.check  = (state_reg == S_CHECK);
    assign cmd.walk   = (state_reg == S_WALK);
    assign cmd.drain  = (state_reg == S_DRAIN);

endmodule
`default_nettype wire

// File: src/pts_datapath.sv
// Datapath of the partition table scanner: sector parsing, table state,
// pending results and the output register. Depends on pts_pkg.
`default_nettype none
module pts_datapath #(
    parameter int MBR_SLOTS = pts_pkg::MBR_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  pts_pkg::cmd_t     cmd,
    output pts_pkg::status_t  st,
    input  wire logic [1:0]   in_func,
    input  wire logic [7:0]   in_byte,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    output pts_pkg::res_t     m_res
);

    localparam int SW = (MBR_SLOTS > 1) ? $clog2(MBR_SLOTS) : 1;
    localparam logic [8:0] MBR_LO = 9'(pts_pkg::MBR_BASE);
    localparam logic [8:0] MBR_HI = 9'(pts_pkg::MBR_BASE + 16 * MBR_SLOTS);
    localparam logic [8:0] OFF_LAST = 9'(pts_pkg::SECTOR_BYTES - 1);

    logic        mode_reg, mode_next;
    logic [15:0] max_reg, max_next;
    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  off_reg, off_next;
    logic        sig_reg, sig_next;
    logic [7:0]  stype_reg [MBR_SLOTS];
    logic [7:0]  stype_next [MBR_SLOTS];
    logic [31:0] sstart_reg [MBR_SLOTS];
    logic [31:0] sstart_next [MBR_SLOTS];
    logic [31:0] slen_reg [MBR_SLOTS];
    logic [31:0] slen_next [MBR_SLOTS];
    logic [31:0] base_reg, base_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] seen_reg, seen_next;
    logic [31:0] sector_reg, sector_next;
    logic [9:0]  slotoff_reg, slotoff_next;
    logic        guid_reg, guid_next;
    logic [63:0] first_reg, first_next;
    logic [63:0] last_reg, last_next;
    logic [15:0] count_reg, count_next;
    logic        secend_reg, secend_next;
    logic        pent_reg, pent_next;
    logic        preq_reg, preq_next;
    logic        pfin_reg, pfin_next;
    logic        fstat_reg, fstat_next;
    logic [31:0] paddr_reg, paddr_next;
    logic [31:0] estart_reg, estart_next;
    logic [31:0] elen_reg, elen_next;
    logic [SW-1:0] widx_reg, widx_next;
    logic        oval_reg, oval_next;
    pts_pkg::res_t out_reg, out_next;

    logic          slot_free;
    logic [8:0]    rel;
    logic [SW-1:0] sidx;
    logic [3:0]    fld;
    logic [8:0]    r;
    logic [9:0]    esize;
    logic          in_slot;
    logic          qual;
    logic [15:0]   cnt;
    logic          wqual;
    logic          sig_cur;
    logic          hdr_bad;

    assign slot_free = !oval_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            max_reg     <= 16'd128;
            phase_reg   <= pts_pkg::PH_IDLE;
            off_reg     <= '0;
            sig_reg     <= 1'b0;
            for (int i = 0; i < MBR_SLOTS; i++)
            begin
                stype_reg[i]  <= '0;
                sstart_reg[i] <= '0;
                slen_reg[i]   <= '0;
            end
            base_reg    <= '0;
            total_reg   <= '0;
            size_reg    <= '0;
            seen_reg    <= '0;
            sector_reg  <= '0;
            slotoff_reg <= '0;
            guid_reg    <= 1'b0;
            first_reg   <= '0;
            last_reg    <= '0;
            count_reg   <= '0;
            secend_reg  <= 1'b0;
            pent_reg    <= 1'b0;
            preq_reg    <= 1'b0;
            pfin_reg    <= 1'b0;
            fstat_reg   <= 1'b0;
            widx_reg    <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            max_reg     <= max_next;
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            sig_reg     <= sig_next;
            stype_reg   <= stype_next;
            sstart_reg  <= sstart_next;
            slen_reg    <= slen_next;
            base_reg    <= base_next;
            total_reg   <= total_next;
            size_reg    <= size_next;
            seen_reg    <= seen_next;
            sector_reg  <= sector_next;
            slotoff_reg <= slotoff_next;
            guid_reg    <= guid_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            secend_reg  <= secend_next;
            pent_reg    <= pent_next;
            preq_reg    <= preq_next;
            pfin_reg    <= pfin_next;
            fstat_reg   <= fstat_next;
            widx_reg    <= widx_next;
            oval_reg    <= oval_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        paddr_reg  <= paddr_next;
        estart_reg <= estart_next;
        elen_reg   <= elen_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        max_next     = max_reg;
        phase_next   = phase_reg;
        off_next     = off_reg;
        sig_next     = sig_reg;
        stype_next   = stype_reg;
        sstart_next  = sstart_reg;
        slen_next    = slen_reg;
        base_next    = base_reg;
        total_next   = total_reg;
        size_next    = size_reg;
        seen_next    = seen_reg;
        sector_next  = sector_reg;
        slotoff_next = slotoff_reg;
        guid_next    = guid_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        secend_next  = secend_reg;
        pent_next    = pent_reg;
        preq_next    = preq_reg;
        pfin_next    = pfin_reg;
        fstat_next   = fstat_reg;
        paddr_next   = paddr_reg;
        estart_next  = estart_reg;
        elen_next    = elen_reg;
        widx_next    = widx_reg;
        oval_next    = oval_reg && !m_tready;
        out_next     = out_reg;
        st           = '0;

        rel     = off_reg - MBR_LO;
        sidx    = SW'(rel[8:4]);
        fld     = rel[3:0];
        esize   = size_reg[9:0];
        in_slot = (({1'b0, slotoff_reg} + {1'b0, esize}) <= 11'd512)
                  && ({1'b0, off_reg} >= slotoff_reg);
        r       = off_reg - slotoff_reg[8:0];
        sig_cur = (off_reg == 9'd0) ? 1'b1 : sig_reg;
        hdr_bad = 1'b0;
        qual    = guid_reg && (last_reg >= first_reg);
        cnt     = count_reg + {15'd0, qual};
        wqual   = (stype_reg[widx_reg] != 8'd0) && (slen_reg[widx_reg] != 32'd0)
                  && ({{(16 - SW){1'b0}}, widx_reg} < max_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                pts_pkg::REG_SCAN_MODE:   mode_next = cfg_data[0];
                pts_pkg::REG_MAX_ENTRIES: max_next  = cfg_data;
                default: ;
            endcase
        end

        if (cmd.accept)
        begin
            if (in_func == pts_pkg::FUNC_START)
            begin
                phase_next  = pts_pkg::PH_MBR;
                off_next    = '0;
                count_next  = '0;
                sig_next    = 1'b0;
                preq_next   = 1'b1;
                paddr_next  = '0;
                st.acc_pend = 1'b1;
            end
            else if (in_func == pts_pkg::FUNC_FAIL)
            begin
                if (phase_reg != pts_pkg::PH_IDLE)
                begin
                    pfin_next   = 1'b1;
                    fstat_next  = 1'b1;
                    phase_next  = pts_pkg::PH_IDLE;
                    st.acc_pend = 1'b1;
                end
            end
            else if (in_func == pts_pkg::FUNC_BYTE && phase_reg != pts_pkg::PH_IDLE)
            begin
                off_next = off_reg + 9'd1;
                sig_next = sig_cur;
                unique case (phase_reg)
                    pts_pkg::PH_MBR:
                    begin
                        if (off_reg >= MBR_LO && off_reg < MBR_HI)
                        begin
                            if (fld == 4'd4)
                                stype_next[sidx] = in_byte;
                            else if (fld >= 4'd8 && fld < 4'd12)
                                sstart_next[sidx][8 * fld[1:0] +: 8] = in_byte;
                            else if (fld >= 4'd12)
                                slen_next[sidx][8 * fld[1:0] +: 8] = in_byte;
                        end
                        if (off_reg == OFF_LAST - 9'd1)
                            sig_next = sig_cur && (in_byte == pts_pkg::SIG_LO);
                        if (off_reg == OFF_LAST)
                        begin
                            sig_next = sig_cur && (in_byte == pts_pkg::SIG_HI);
                            if (!sig_next)
                            begin
                                pfin_next   = 1'b1;
                                fstat_next  = 1'b0;
                                phase_next  = pts_pkg::PH_IDLE;
                                st.acc_pend = 1'b1;
                            end
                            else if (!mode_reg)
                            begin
                                phase_next    = pts_pkg::PH_IDLE;
                                widx_next     = '0;
                                st.walk_start = 1'b1;
                            end
                            else
                            begin
                                phase_next  = pts_pkg::PH_HDR;
                                preq_next   = 1'b1;
                                paddr_next  = 32'd1;
                                st.acc_pend = 1'b1;
                            end
                        end
                    end
                    pts_pkg::PH_HDR:
                    begin
                        if (off_reg < 9'd8)
                            sig_next = sig_cur && (in_byte == pts_pkg::efi_magic(off_reg[2:0]));
                        if (off_reg >= 9'(pts_pkg::HDR_LBA_OFF)
                            && off_reg < 9'(pts_pkg::HDR_LBA_OFF + 4))
                            base_next[8 * off_reg[1:0] +: 8] = in_byte;
                        if (off_reg >= 9'(pts_pkg::HDR_CNT_OFF)
                            && off_reg < 9'(pts_pkg::HDR_CNT_OFF + 4))
                            total_next[8 * off_reg[1:0] +: 8] = in_byte;
                        if (off_reg >= 9'(pts_pkg::HDR_SIZE_OFF)
                            && off_reg < 9'(pts_pkg::HDR_SIZE_OFF + 4))
                            size_next[8 * off_reg[1:0] +: 8] = in_byte;
                        if (off_reg == OFF_LAST)
                        begin
                            hdr_bad = !sig_cur
                                      || size_reg < 32'(pts_pkg::MIN_ENTRY)
                                      || size_reg > 32'(pts_pkg::SECTOR_BYTES)
                                      || total_reg == 32'd0 || max_reg == 16'd0;
                            st.acc_pend = 1'b1;
                            if (hdr_bad)
                            begin
                                pfin_next  = 1'b1;
                                fstat_next = 1'b0;
                                phase_next = pts_pkg::PH_IDLE;
                            end
                            else
                            begin
                                seen_next    = '0;
                                sector_next  = '0;
                                slotoff_next = '0;
                                guid_next    = 1'b0;
                                first_next   = '0;
                                last_next    = '0;
                                phase_next   = pts_pkg::PH_ENT;
                                preq_next    = 1'b1;
                                paddr_next   = base_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_slot)
                        begin
                            if (r >= 9'd16 && r < 9'd32 && in_byte != 8'd0)
                                guid_next = 1'b1;
                            if (r >= 9'd32 && r < 9'd40)
                                first_next[8 * r[2:0] +: 8] = in_byte;
                            if (r >= 9'd40 && r < 9'd48)
                                last_next[8 * r[2:0] +: 8] = in_byte;
                            if ({1'b0, r} == esize - 10'd1)
                            begin
                                seen_next     = seen_reg + 32'd1;
                                slotoff_next  = slotoff_reg + esize;
                                st.need_check = 1'b1;
                            end
                        end
                        secend_next = (off_reg == OFF_LAST);
                        if (off_reg == OFF_LAST)
                        begin
                            sector_next  = sector_reg + 32'd1;
                            slotoff_next = '0;
                            if (!st.need_check)
                            begin
                                guid_next   = 1'b0;
                                first_next  = '0;
                                last_next   = '0;
                                preq_next   = 1'b1;
                                paddr_next  = base_reg + sector_reg + 32'd1;
                                st.acc_pend = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        // entry completion: qualify, count, decide on finish or next-sector request
        if (cmd.check)
        begin
            guid_next   = 1'b0;
            first_next  = '0;
            last_next   = '0;
            secend_next = 1'b0;
            if (qual)
            begin
                count_next  = cnt;
                pent_next   = 1'b1;
                estart_next = first_reg[31:0];
                elen_next   = last_reg[31:0] - first_reg[31:0] + 32'd1;
            end
            if (seen_reg >= total_reg || cnt >= max_reg)
            begin
                pfin_next  = 1'b1;
                fstat_next = 1'b0;
                phase_next = pts_pkg::PH_IDLE;
            end
            else if (secend_reg)
            begin
                preq_next  = 1'b1;
                paddr_next = base_reg + sector_reg;
            end
            st.check_pend = qual || (seen_reg >= total_reg) || (cnt >= max_reg)
                            || secend_reg;
        end

        // walk MBR slots, one a cycle; hold on a busy output
        if (cmd.walk && (!wqual || slot_free))
        begin
            if (wqual)
            begin
                count_next = count_reg + 16'd1;
                oval_next  = 1'b1;
                out_next   = '{kind: pts_pkg::KIND_ENTRY, addr: 32'd0,
                               ptype: stype_reg[widx_reg], pstart: sstart_reg[widx_reg],
                               plen: slen_reg[widx_reg], status: 1'b0,
                               count: count_reg + 16'd1, last: 1'b0};
            end
            if (widx_reg == SW'(MBR_SLOTS - 1))
            begin
                pfin_next    = 1'b1;
                fstat_next   = 1'b0;
                st.walk_done = 1'b1;
            end
            else
            begin
                widx_next = widx_reg + SW'(1);
            end
        end

        // drain pending results in order: entry, request, finish
        if (cmd.drain && slot_free)
        begin
            oval_next = 1'b1;
            priority if (pent_reg)
            begin
                pent_next = 1'b0;
                out_next  = '{kind: pts_pkg::KIND_ENTRY, addr: 32'd0,
                              ptype: pts_pkg::GPT_TYPE, pstart: estart_reg,
                              plen: elen_reg, status: 1'b0, count: count_reg,
                              last: !(preq_reg || pfin_reg)};
                st.load_last = !(preq_reg || pfin_reg);
            end
            else if (preq_reg)
            begin
                preq_next = 1'b0;
                out_next  = '{kind: pts_pkg::KIND_REQ, addr: paddr_reg, ptype: 8'd0,
                              pstart: 32'd0, plen: 32'd0, status: 1'b0,
                              count: count_reg, last: !pfin_reg};
                st.load_last = !pfin_reg;
            end
            else if (pfin_reg)
            begin
                pfin_next = 1'b0;
                out_next  = '{kind: pts_pkg::KIND_DONE, addr: 32'd0, ptype: 8'd0,
                              pstart: 32'd0, plen: 32'd0, status: fstat_reg,
                              count: count_reg, last: 1'b1};
                st.load_last = 1'b1;
            end
            else
            begin
                oval_next    = oval_reg && !m_tready;
                st.load_last = 1'b1;
            end
        end
    end

    assign m_tvalid = oval_reg;
    assign m_res    = out_reg;

endmodule
`default_nettype wire

// File: src/partition_table_scanner_unit.sv
// Top level of the partition table scanner: stream ports and config port.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
//  channel   direction  handshake          payload
//  ------    ---------  ---------          -------
//  s_*       in         s_tvalid/s_tready  s_tdata: data_byte; s_tuser: func
//  m_*       out        m_tvalid/m_tready  m_tdata: result fields; m_tuser: kind;
//                                          m_tlast: last
//  cfg_*     in         cfg_we             cfg_index, cfg_data (no read-back)
//
// A byte transfer that completes nothing keeps the input ready, so sector
// bytes stream at one per cycle. A byte that closes a GPT entry enters the
// entry check (64-bit compare and length subtract). Each result passes the
// single output register, held while m_tready is low; closing the MBR sector
// walks the slots one per cycle when the output is free, before the finish.
// Input stays stalled until every result of the transfer is in the output
// register. Reset is asynchronous; it clears all control and table state.
`default_nettype none
module partition_table_scanner_unit #(
    parameter int MBR_SLOTS = pts_pkg::MBR_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]   s_tuser,   // [1:0] func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] sector_address, [39:32] part_type, [71:40] part_start,
    // [103:72] part_length, [104] scan_status, [120:105] found_count, rest zero
    output logic [127:0]      m_tdata,
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data
);

    pts_pkg::cmd_t    cmd;
    pts_pkg::status_t st;
    pts_pkg::res_t    res;

    // sequencing: accept, entry check, slot walk, result drain
    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pts_datapath #(
        .MBR_SLOTS (MBR_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_func   (s_tuser),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (res)
    );

    // pack the result, first field lowest
    assign m_tdata = {7'd0, res.count, res.status, res.plen, res.pstart,
                      res.ptype, res.addr};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // an entry check always follows an accepted transfer
    a_check_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> $past(cmd.accept))
        else $error("entry check without a preceding accept");

    // the last result loaded hands control back to input
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain && st.load_last) |=> s_tready)
        else $error("input not reopened after last result");

    // a walk never overlaps input acceptance
    a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> !s_tready)
        else $error("input open during slot walk");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for partition_table_scanner_unit: directed scan table
// plus random MBR/GPT scans, all results checked by an in-bench scan predictor.
// Depends on pts_pkg and the RTL under src/.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  ptype;
        logic [31:0] pstart;
        logic [31:0] plen;
        logic        status;
        logic [15:0] count;
        logic        last;
    } scan_res_t;

    typedef struct {
        logic [1:0] func;
        logic [7:0] data;
    } scan_item_t;

    // directed row: item plus an optional hand-typed first result
    typedef struct {
        logic [1:0] func;
        logic [7:0] data;
        bit         typed;
        logic [1:0] kind;
        logic [15:0] count;
        logic        status;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    partition_table_scanner_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- scan predictor state ----------------
    logic        mode_gpt;
    logic [15:0] entry_limit;
    logic [1:0]  scan_phase;
    logic [8:0]  sec_pos;
    logic        sig_good;
    logic [7:0]  slot_type [4];
    logic [31:0] slot_start [4];
    logic [31:0] slot_len [4];
    logic [31:0] tbl_lba;
    logic [31:0] tbl_total;
    logic [31:0] tbl_size;
    logic [31:0] ent_done;
    logic [31:0] sec_num;
    logic [31:0] ent_base;
    logic        guid_set;
    logic [63:0] lba_first;
    logic [63:0] lba_last;
    logic [15:0] found;

    scan_res_t   expected_results[$];
    scan_res_t   step_out[$];
    int          error_count;
    int          accepted_items;
    longint      cycle_count;

    // exact hand-typed expectations keyed by position in the result stream
    int          typed_at[$];
    scan_res_t   typed_val[$];
    int          results_seen;

    function automatic logic [7:0] magic_byte(int k);
        logic [63:0] s;
        s = "EFI PART";
        return s[63 - 8*k -: 8];
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [31:0] addr,
            logic [7:0] pt, logic [31:0] ps, logic [31:0] pl, logic st);
        scan_res_t r;
        r.kind = kind; r.addr = addr; r.ptype = pt; r.pstart = ps; r.plen = pl;
        r.status = st; r.count = found; r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void finish_scan(logic st);
        push_result(pts_pkg::KIND_DONE, 0, 0, 0, 0, st);
        scan_phase = pts_pkg::PH_IDLE;
    endfunction

    function automatic void clear_ent();
        guid_set = 1'b0; lba_first = '0; lba_last = '0;
    endfunction

    function automatic void predict_mbr(int off, logic [7:0] b);
        int rel, s, f;
        if (off >= pts_pkg::MBR_BASE && off < pts_pkg::MBR_BASE + 64) begin
            rel = off - pts_pkg::MBR_BASE; s = rel >> 4; f = rel & 15;
            if (f == 4) slot_type[s] = b;
            else if (f >= 8 && f < 12) slot_start[s][8*(f-8) +: 8] = b;
            else if (f >= 12) slot_len[s][8*(f-12) +: 8] = b;
        end
        if (off == 510) sig_good = sig_good && b == pts_pkg::SIG_LO;
        if (off == 511) sig_good = sig_good && b == pts_pkg::SIG_HI;
        if (off != pts_pkg::SECTOR_BYTES - 1) return;
        if (!sig_good) begin finish_scan(0); return; end
        if (!mode_gpt) begin
            for (int i = 0; i < 4 && i < int'(entry_limit); i++)
                if (slot_type[i] != 0 && slot_len[i] != 0) begin
                    found++;
                    push_result(pts_pkg::KIND_ENTRY, 0, slot_type[i], slot_start[i],
                                slot_len[i], 0);
                end
            finish_scan(0);
        end else begin
            scan_phase = pts_pkg::PH_HDR;
            push_result(pts_pkg::KIND_REQ, 1, 0, 0, 0, 0);
        end
    endfunction

    function automatic void predict_hdr(int off, logic [7:0] b);
        if (off < 8) sig_good = sig_good && b == magic_byte(off);
        if (off >= 72 && off < 76) tbl_lba[8*(off-72) +: 8] = b;
        if (off >= 80 && off < 84) tbl_total[8*(off-80) +: 8] = b;
        if (off >= 84 && off < 88) tbl_size[8*(off-84) +: 8] = b;
        if (off != pts_pkg::SECTOR_BYTES - 1) return;
        if (!sig_good || tbl_size < pts_pkg::MIN_ENTRY || tbl_size > 512 || tbl_total == 0
            || entry_limit == 0) begin
            finish_scan(0);
            return;
        end
        ent_done = 0; sec_num = 0; ent_base = 0; clear_ent();
        scan_phase = pts_pkg::PH_ENT;
        push_result(pts_pkg::KIND_REQ, tbl_lba, 0, 0, 0, 0);
    endfunction

    function automatic void predict_ent(int off, logic [7:0] b);
        int r;
        logic [63:0] span;
        if (ent_base + tbl_size <= 512 && off >= ent_base) begin
            r = off - ent_base;
            if (r >= 16 && r < 32 && b != 0) guid_set = 1'b1;
            if (r >= 32 && r < 40) lba_first[8*(r-32) +: 8] = b;
            if (r >= 40 && r < 48) lba_last[8*(r-40) +: 8] = b;
            if (r == tbl_size - 1) begin
                if (guid_set && lba_last >= lba_first) begin
                    found++;
                    span = lba_last - lba_first + 64'd1;
                    push_result(pts_pkg::KIND_ENTRY, 0, pts_pkg::GPT_TYPE, lba_first[31:0],
                                span[31:0], 0);
                end
                ent_done++;
                ent_base += tbl_size;
                clear_ent();
                if (ent_done >= tbl_total || found >= entry_limit) begin
                    finish_scan(0);
                    return;
                end
            end
        end
        if (off == pts_pkg::SECTOR_BYTES - 1) begin
            sec_num++; ent_base = 0; clear_ent();
            push_result(pts_pkg::KIND_REQ, tbl_lba + sec_num, 0, 0, 0, 0);
        end
    endfunction

    // work out the results of one accepted item and queue them
    function automatic void predict_scan_step(logic [1:0] func, logic [7:0] b);
        int off;
        step_out.delete();
        if (func == pts_pkg::FUNC_START) begin
            scan_phase = pts_pkg::PH_MBR; sec_pos = 0; found = 0; sig_good = 1'b0;
            push_result(pts_pkg::KIND_REQ, 0, 0, 0, 0, 0);
        end else if (func == pts_pkg::FUNC_FAIL) begin
            if (scan_phase != pts_pkg::PH_IDLE) finish_scan(1);
        end else if (func == pts_pkg::FUNC_BYTE && scan_phase != pts_pkg::PH_IDLE) begin
            off = sec_pos;
            sec_pos = sec_pos + 9'd1;
            if (off == 0) sig_good = 1'b1;
            if (scan_phase == pts_pkg::PH_MBR) predict_mbr(off, b);
            else if (scan_phase == pts_pkg::PH_HDR) predict_hdr(off, b);
            else predict_ent(off, b);
        end
        if (step_out.size() > 0) step_out[$].last = 1'b1;
        foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endfunction

    function automatic void reset_model();
        mode_gpt = 0; entry_limit = 128; scan_phase = pts_pkg::PH_IDLE; sec_pos = 0;
        sig_good = 0;
        for (int i = 0; i < 4; i++) begin
            slot_type[i] = 0; slot_start[i] = 0; slot_len[i] = 0;
        end
        tbl_lba = 0; tbl_total = 0; tbl_size = 0; ent_done = 0; sec_num = 0;
        ent_base = 0; clear_ent(); found = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [127:0] got,
            input logic [127:0] want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------- result checker and receiver ----------------
    int  hold_off_cycles;
    bit  no_idle;

    always @(posedge clk) begin
        scan_res_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else begin
                e = expected_results.pop_front();
                if (typed_at.size() > 0 && typed_at[0] == results_seen) begin
                    void'(typed_at.pop_front());
                    if (typed_val[0].count !== e.count || typed_val[0].status !== e.status
                        || typed_val[0].kind !== e.kind)
                        report_mismatch("typed row vs predictor", 0, 0);
                    void'(typed_val.pop_front());
                end
                if (m_tuser !== e.kind) report_mismatch("kind", m_tuser, e.kind);
                if (m_tdata[31:0] !== e.addr)
                    report_mismatch("sector_address", m_tdata[31:0], e.addr);
                if (m_tdata[39:32] !== e.ptype)
                    report_mismatch("part_type", m_tdata[39:32], e.ptype);
                if (m_tdata[71:40] !== e.pstart)
                    report_mismatch("part_start", m_tdata[71:40], e.pstart);
                if (m_tdata[103:72] !== e.plen)
                    report_mismatch("part_length", m_tdata[103:72], e.plen);
                if (m_tdata[104] !== e.status)
                    report_mismatch("scan_status", m_tdata[104], e.status);
                if (m_tdata[120:105] !== e.count)
                    report_mismatch("found_count", m_tdata[120:105], e.count);
                if (m_tdata[127:121] !== '0)
                    report_mismatch("tdata pad", m_tdata[127:121], 0);
                if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
            end
            results_seen++;
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
    end

    always @(posedge clk) cycle_count++;
    initial begin
        wait (cycle_count > 3_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- stimulus ----------------
    scan_item_t stim_q[$];
    dir_row_t   dir_rows[$];

    // send one item, keep offering it until the block takes it
    task automatic send_item(input logic [1:0] func, input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 15) begin
            @(posedge clk);
            s_tvalid <= 1'b0;
        end
        @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        predict_scan_step(func, b);
        accepted_items++;
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        while (expected_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pts_pkg::REG_SCAN_MODE) mode_gpt = val[0];
        else entry_limit = val;
    endtask

    // Build a sector into stim_q. Fill bytes are random.
    task automatic add_mbr(input bit good_sig);
        logic [7:0] sec [512];
        for (int i = 0; i < 512; i++) sec[i] = 8'($urandom);
        for (int s = 0; s < 4; s++) begin
            if ($urandom_range(3) == 0) sec[pts_pkg::MBR_BASE + 16*s + 4] = 0;
            if ($urandom_range(4) == 0)
                for (int k = 12; k < 16; k++) sec[pts_pkg::MBR_BASE + 16*s + k] = 0;
        end
        if (good_sig) begin sec[510] = pts_pkg::SIG_LO; sec[511] = pts_pkg::SIG_HI; end
        else if ($urandom_range(1)) sec[510] = pts_pkg::SIG_LO;
        for (int i = 0; i < 512; i++) stim_q.push_back('{pts_pkg::FUNC_BYTE, sec[i]});
    endtask

    task automatic add_hdr(input bit good, input logic [31:0] lba, input logic [31:0] cnt,
            input logic [31:0] esize);
        logic [7:0] sec [512];
        for (int i = 0; i < 512; i++) sec[i] = 8'($urandom);
        for (int k = 0; k < 8; k++) sec[k] = magic_byte(k);
        if (!good) sec[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
        for (int k = 0; k < 4; k++) begin
            sec[72+k] = lba[8*k +: 8]; sec[80+k] = cnt[8*k +: 8];
            sec[84+k] = esize[8*k +: 8];
        end
        for (int i = 0; i < 512; i++) stim_q.push_back('{pts_pkg::FUNC_BYTE, sec[i]});
    endtask

    task automatic add_entry_sector(input int esize);
        logic [7:0] sec [512];
        logic [63:0] f, l;
        for (int i = 0; i < 512; i++) sec[i] = 8'($urandom);
        for (int base = 0; base + esize <= 512; base += esize) begin
            if ($urandom_range(4) == 0)
                for (int k = 16; k < 32; k++) sec[base+k] = 0;
            f = {$urandom, $urandom};
            if ($urandom_range(3) == 0) f[63:32] = 0;
            case ($urandom_range(3))
                0: l = f;
                1: l = f - 1;
                default: l = f + $urandom_range(100000);
            endcase
            if ($urandom_range(9) == 0) l = {$urandom, $urandom};
            for (int k = 0; k < 8; k++) begin
                sec[base+32+k] = f[8*k +: 8]; sec[base+40+k] = l[8*k +: 8];
            end
        end
        for (int i = 0; i < 512; i++) stim_q.push_back('{pts_pkg::FUNC_BYTE, sec[i]});
    endtask

    task automatic drain_stim();
        while (stim_q.size() > 0) begin
            scan_item_t it;
            it = stim_q.pop_front();
            send_item(it.func, it.data);
        end
    endtask

    // Random scans; shapes are mostly well-formed, some broken and noise.
    task automatic random_scan(input bit gpt);
        int esize, cnt, cut;
        stim_q.push_back('{pts_pkg::FUNC_START, 8'($urandom)});
        if (!gpt) add_mbr($urandom_range(7) != 0);
        else begin
            add_mbr($urandom_range(9) != 0);
            case ($urandom_range(9))
                0: esize = $urandom_range(47);
                1: esize = 512 + $urandom_range(3);
                2: esize = 48;
                3: esize = 512;
                4: esize = 128;
                default: esize = 48 + $urandom_range(200);
            endcase
            cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            add_hdr($urandom_range(9) != 0, $urandom, cnt, esize);
            for (int s = 0; s < 3; s++) add_entry_sector(esize < 48 ? 48 : esize);
        end
        // sometimes break the scan early with a failure, restart or noise
        if ($urandom_range(4) == 0) begin
            cut = $urandom_range(stim_q.size() - 1);
            case ($urandom_range(2))
                0: stim_q[cut] = '{pts_pkg::FUNC_FAIL, 8'($urandom)};
                1: stim_q[cut] = '{pts_pkg::FUNC_START, 8'($urandom)};
                default: stim_q[cut] = '{2'd3, 8'($urandom)};
            endcase
            while (stim_q.size() > cut + 1 + $urandom_range(600)) void'(stim_q.pop_back());
        end
        drain_stim();
        if ($urandom_range(2) == 0) send_item(pts_pkg::FUNC_FAIL, 8'($urandom));
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = pts_pkg::FUNC_START;
        cfg_we = 1'b0; cfg_index = pts_pkg::REG_SCAN_MODE; cfg_data = '0;
        hold_off_cycles = 0; no_idle = 0;
        error_count = 0; accepted_items = 0; cycle_count = 0; results_seen = 0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: idle noise ignored, read-failure finish, restart, bad fn.
        dir_rows = '{
            '{pts_pkg::FUNC_BYTE,  8'hFF, 0, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_FAIL,  8'h00, 0, pts_pkg::KIND_REQ, 0, 0},
            '{2'd3,                8'hA5, 0, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_START, 8'h00, 1, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_START, 8'hFF, 1, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_BYTE,  8'h00, 0, pts_pkg::KIND_REQ, 0, 0},
            '{2'd3,                8'hFF, 0, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_FAIL,  8'hFF, 1, pts_pkg::KIND_DONE, 0, 1},
            '{pts_pkg::FUNC_FAIL,  8'h00, 0, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_START, 8'h5A, 1, pts_pkg::KIND_REQ, 0, 0},
            '{pts_pkg::FUNC_FAIL,  8'h00, 1, pts_pkg::KIND_DONE, 0, 1}
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                scan_res_t t;
                t.kind = dir_rows[i].kind; t.count = dir_rows[i].count;
                t.status = dir_rows[i].status;
                typed_at.push_back(results_seen + expected_results.size());
                typed_val.push_back(t);
            end
            send_item(dir_rows[i].func, dir_rows[i].data);
        end
        settle();

        // MBR extremes: random table at default limit, then limit 1.
        random_scan(0);
        settle();
        write_reg(pts_pkg::REG_MAX_ENTRIES, 16'd1);
        random_scan(0);
        settle();

        // GPT with one long receiver hold-off while bytes keep coming; it
        // outlasts the first sector so the output register fills and input stalls.
        write_reg(pts_pkg::REG_SCAN_MODE, 16'd1);
        write_reg(pts_pkg::REG_MAX_ENTRIES, 16'hFFFF);
        hold_off_cycles = 3000;
        random_scan(1);
        settle();

        // random phases over settings; one stretch without idling
        for (int ph = 0; ph < 10; ph++) begin
            no_idle = (ph == 4);
            write_reg(pts_pkg::REG_SCAN_MODE, 16'($urandom_range(1)));
            write_reg(pts_pkg::REG_MAX_ENTRIES, ph == 6 ? 16'd1 : (ph == 7 ? 16'hFFFF
                      : 16'($urandom_range(1, 6))));
            random_scan(mode_gpt);
            settle();
        end
        no_idle = 0;
        settle();
        if (expected_results.size() == 0 && error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
